// File: hw/rtl/rtsc_pkg.sv
// ----------------------------------------------------------------------------
// rtsc_pkg
// Shared types and constants of the resistive touch scan controller.
// ----------------------------------------------------------------------------
package rtsc_pkg;

   localparam int STEP_W   = 6;
   localparam int SAMPLE_W = 12;
   localparam int THRESH_W = 13;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 13;

   localparam logic [7:0] CMD_Z1   = 8'hB1;
   localparam logic [7:0] CMD_Z2   = 8'hC1;
   localparam logic [7:0] CMD_X    = 8'hD1;
   localparam logic [7:0] CMD_Y    = 8'h91;
   localparam logic [7:0] CMD_NONE = 8'h00;

   localparam logic [SAMPLE_W-1:0] FULL_SCALE = 12'hFFF;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 13'd400;
   localparam logic                PEN_EN_RESET = 1'b1;

   localparam logic EV_SCAN = 1'b0;
   localparam logic EV_BYTE = 1'b1;

   localparam logic RES_TX     = 1'b0;
   localparam logic RES_REPORT = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PEN_EN    = 1'b1;

   localparam logic [1:0] PH_CMD  = 2'd0;
   localparam logic [1:0] PH_HIGH = 2'd1;
   localparam logic [1:0] PH_LOW  = 2'd2;

   localparam logic [STEP_W-1:0] STEP_Z2    = 6'd3;
   localparam logic [STEP_W-1:0] STEP_READS = 6'd6;
   localparam logic [STEP_W-1:0] STEP_TAIL  = 6'd9;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_BUSY = 2'b10
   } state_type;

   typedef struct packed {
      logic       event_kind;
      logic       pen_irq_asserted;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic                result_kind;
      logic [7:0]          tx_byte;
      logic                select_active;
      logic                pressed;
      logic [SAMPLE_W-1:0] x_position;
      logic [SAMPLE_W-1:0] y_position;
   } rsp_type;

endpackage

// File: hw/rtl/rtsc_req_if.sv
// ----------------------------------------------------------------------------
// rtsc_req_if
// Input channel: scan requests and received link bytes.
// ----------------------------------------------------------------------------
interface rtsc_req_if;
   logic       valid;
   logic       ready;
   logic       event_kind;
   logic       pen_irq_asserted;
   logic [7:0] rx_byte;

   modport source (output valid, output event_kind, output pen_irq_asserted,
                   output rx_byte, input ready);
   modport sink (input valid, input event_kind, input pen_irq_asserted,
                 input rx_byte, output ready);
endinterface

// File: hw/rtl/rtsc_rsp_if.sv
// ----------------------------------------------------------------------------
// rtsc_rsp_if
// Result channel: bytes to transmit and touch reports.
// ----------------------------------------------------------------------------
interface rtsc_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [7:0]  tx_byte;
   logic        select_active;
   logic        pressed;
   logic [11:0] x_position;
   logic [11:0] y_position;

   modport source (output valid, output result_kind, output tx_byte,
                   output select_active, output pressed, output x_position,
                   output y_position, input ready);
   modport sink (input valid, input result_kind, input tx_byte,
                 input select_active, input pressed, input x_position,
                 input y_position, output ready);
endinterface

// File: hw/rtl/rtsc_average.sv
// ----------------------------------------------------------------------------
// rtsc_average
// Sum divided by the sample count through a reciprocal multiply, clamped.
// ----------------------------------------------------------------------------
module rtsc_average
   import rtsc_pkg::*;
#(
   parameter int SAMPLES = 3,
   parameter int SUM_W   = 14
) (
   input  logic [SUM_W-1:0]    sum,
   output logic [SAMPLE_W-1:0] avg
);

   localparam int SHIFT  = SUM_W + 3;
   localparam int MULT_W = SHIFT + 1;
   localparam logic [MULT_W-1:0] MULT =
      MULT_W'(((64'd1 << SHIFT) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));

   logic [SUM_W+MULT_W-1:0] product;
   logic [SUM_W-1:0]        quotient;

   assign product  = (SUM_W+MULT_W)'(sum) * (SUM_W+MULT_W)'(MULT);
   assign quotient = product[SHIFT +: SUM_W];
   assign avg      = (quotient > SUM_W'(FULL_SCALE)) ? FULL_SCALE
                                                     : quotient[SAMPLE_W-1:0];

endmodule

// File: hw/rtl/rtsc_sequencer.sv
// ----------------------------------------------------------------------------
// rtsc_sequencer
// Scan state, sample capture, pressure test and accumulation; one item per
// cycle while fire is high, at most one result per item.
// ----------------------------------------------------------------------------
module rtsc_sequencer
   import rtsc_pkg::*;
#(
   parameter int SAMPLES = 3
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  req_type             item,
   input  logic [THRESH_W-1:0] pressure_threshold,
   input  logic                pen_irq_enable,
   output logic                has_result,
   output rsp_type             result
);

   localparam int SUM_W = $clog2(SAMPLES * 4095 + 1);
   localparam int READS = 6 * SAMPLES;

   state_type           state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [1:0]          phase_ff, phase_in;
   logic                axis_ff, axis_in;
   logic [7:0]          high_ff, high_in;
   logic [SAMPLE_W-1:0] z1_ff, z1_in;
   logic                touch_ff, touch_in;
   logic [SUM_W-1:0]    xsum_ff, xsum_in;
   logic [SUM_W-1:0]    ysum_ff, ysum_in;

   logic [15:0]         rx_word;
   logic [SAMPLE_W-1:0] sample;
   logic                touch_next;
   logic [STEP_W-1:0]   reads_len;
   logic [STEP_W-1:0]   reads_end;
   logic [STEP_W-1:0]   t_next;
   logic [1:0]          phase_next;
   logic                axis_next;
   logic                last;
   logic [THRESH_W-1:0] pressure;
   logic [7:0]          next_byte;
   logic [SAMPLE_W-1:0] x_avg, y_avg;

   rtsc_average #(.SAMPLES(SAMPLES), .SUM_W(SUM_W)) u_avg_x (
      .sum (xsum_ff),
      .avg (x_avg)
   );

   rtsc_average #(.SAMPLES(SAMPLES), .SUM_W(SUM_W)) u_avg_y (
      .sum (ysum_ff),
      .avg (y_avg)
   );

   assign rx_word    = {high_ff, item.rx_byte};
   assign sample     = rx_word[14:3];
   assign touch_next = (phase_ff == PH_LOW && step_ff >= STEP_Z2 && step_ff < STEP_READS)
                       ? (pressure >= pressure_threshold) : touch_ff;
   assign reads_len  = touch_next ? STEP_W'(READS) : '0;
   assign reads_end  = STEP_READS + reads_len;
   assign t_next     = step_ff + STEP_W'(1);
   assign last       = t_next >= (STEP_TAIL + reads_len);
   assign phase_next = (phase_ff == PH_LOW) ? PH_CMD : phase_ff + 2'd1;
   assign axis_next  = (phase_next == PH_CMD && t_next >= STEP_TAIL) ? ~axis_ff : axis_ff;
   assign pressure   = (z1_ff == '0) ? '0
                       : THRESH_W'(z1_ff) + THRESH_W'(FULL_SCALE - sample);

   always_comb begin
      next_byte = CMD_NONE;
      if (phase_next == PH_CMD) begin
         if (t_next == STEP_Z2) begin
            next_byte = CMD_Z2;
         end else if (t_next >= STEP_READS && t_next < reads_end) begin
            next_byte = axis_next ? CMD_Y : CMD_X;
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      phase_in   = phase_ff;
      axis_in    = axis_ff;
      high_in    = high_ff;
      z1_in      = z1_ff;
      touch_in   = touch_ff;
      xsum_in    = xsum_ff;
      ysum_in    = ysum_ff;
      has_result = 1'b0;
      result     = '0;
      if (fire) begin
         if (item.event_kind == EV_SCAN) begin
            if (state_ff == ST_IDLE) begin
               has_result = 1'b1;
               if (pen_irq_enable && !item.pen_irq_asserted) begin
                  result.result_kind = RES_REPORT;
               end else begin
                  state_in = ST_BUSY;
                  step_in  = '0;
                  phase_in = PH_CMD;
                  axis_in  = 1'b0;
                  high_in  = '0;
                  z1_in    = '0;
                  touch_in = 1'b0;
                  xsum_in  = '0;
                  ysum_in  = '0;
                  result.result_kind   = RES_TX;
                  result.tx_byte       = CMD_Z1;
                  result.select_active = 1'b1;
               end
            end
         end else if (state_ff == ST_BUSY) begin
            case (phase_ff)
               PH_CMD: begin
               end
               PH_HIGH: begin
                  high_in = item.rx_byte;
               end
               PH_LOW: begin
                  if (step_ff < STEP_Z2) begin
                     z1_in = sample;
                  end else if (step_ff < STEP_READS) begin
                     touch_in = pressure >= pressure_threshold;
                  end else if (step_ff < reads_end) begin
                     if (axis_ff) begin
                        ysum_in = ysum_ff + SUM_W'(sample);
                     end else begin
                        xsum_in = xsum_ff + SUM_W'(sample);
                     end
                  end
               end
               default: begin
               end
            endcase
            has_result = 1'b1;
            if (last) begin
               state_in = ST_IDLE;
               step_in  = '0;
               phase_in = PH_CMD;
               axis_in  = 1'b0;
               high_in  = '0;
               z1_in    = '0;
               touch_in = 1'b0;
               xsum_in  = '0;
               ysum_in  = '0;
               result.result_kind = RES_REPORT;
               result.pressed     = touch_ff;
               result.x_position  = touch_ff ? x_avg : '0;
               result.y_position  = touch_ff ? y_avg : '0;
            end else begin
               step_in  = t_next;
               phase_in = phase_next;
               axis_in  = axis_next;
               result.result_kind   = RES_TX;
               result.tx_byte       = next_byte;
               result.select_active = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         phase_ff <= PH_CMD;
         axis_ff  <= 1'b0;
         high_ff  <= '0;
         z1_ff    <= '0;
         touch_ff <= 1'b0;
         xsum_ff  <= '0;
         ysum_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         phase_ff <= phase_in;
         axis_ff  <= axis_in;
         high_ff  <= high_in;
         z1_ff    <= z1_in;
         touch_ff <= touch_in;
         xsum_ff  <= xsum_in;
         ysum_ff  <= ysum_in;
      end
   end

endmodule

// File: hw/rtl/resistive_touch_scan_controller.sv
// ----------------------------------------------------------------------------
// resistive_touch_scan_controller
// Host-side scan sequencer for a resistive touch ADC on a full-duplex link.
//
// req_ch carries scan requests (event_kind 0) and bytes received from the
// link (event_kind 1). rsp_ch returns, per item, at most one result: a byte
// to transmit with select active, or a touch report with pressure flag and
// averaged X/Y positions. Requests while a scan runs and bytes while idle
// give no result.
// An accepted item is held in the input register until it advances; its
// result is then registered in the result register, which drives rsp_ch.valid.
// One item is accepted every cycle; the input register and the result
// register each hold one item, so the input keeps flowing until both are
// full while rsp_ch.ready is low, then req_ch.ready drops.
// Synchronous reset empties both registers, ends any scan and restores the
// pressure threshold to 400 and pen interrupt checking to on.
// csr_* writes take effect at the clock edge with csr_write_en high; the user
// must make them only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module resistive_touch_scan_controller
   import rtsc_pkg::*;
#(
   parameter int SAMPLES = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   rtsc_req_if.sink              req_ch,
   rtsc_rsp_if.source            rsp_ch,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic                in_valid_ff, in_valid_in;
   req_type             in_item_ff;
   logic                out_valid_ff, out_valid_in;
   rsp_type             out_item_ff;
   logic [THRESH_W-1:0] threshold_ff, threshold_in;
   logic                pen_en_ff, pen_en_in;

   logic    advance;
   logic    seq_has;
   rsp_type seq_result;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign in_valid_in  = (req_ch.valid && req_ch.ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance ? seq_has : (out_valid_ff && !rsp_ch.ready);

   rtsc_sequencer #(.SAMPLES(SAMPLES)) u_seq (
      .clock              (clock),
      .reset              (reset),
      .fire               (advance),
      .item               (in_item_ff),
      .pressure_threshold (threshold_ff),
      .pen_irq_enable     (pen_en_ff),
      .has_result         (seq_has),
      .result             (seq_result)
   );

   always_comb begin
      threshold_in = threshold_ff;
      pen_en_in    = pen_en_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_THRESHOLD: threshold_in = csr_wdata[THRESH_W-1:0];
            CSR_PEN_EN:    pen_en_in    = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         threshold_ff <= THRESH_RESET;
         pen_en_ff    <= PEN_EN_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         threshold_ff <= threshold_in;
         pen_en_ff    <= pen_en_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_item_ff.event_kind       <= req_ch.event_kind;
         in_item_ff.pen_irq_asserted <= req_ch.pen_irq_asserted;
         in_item_ff.rx_byte          <= req_ch.rx_byte;
      end
      if (advance && seq_has) begin
         out_item_ff <= seq_result;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.result_kind   = out_item_ff.result_kind;
   assign rsp_ch.tx_byte       = out_item_ff.tx_byte;
   assign rsp_ch.select_active = out_item_ff.select_active;
   assign rsp_ch.pressed       = out_item_ff.pressed;
   assign rsp_ch.x_position    = out_item_ff.x_position;
   assign rsp_ch.y_position    = out_item_ff.y_position;

`ifndef SYNTHESIS
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_item_ff))
      else $error("input register lost or changed a stalled item");

   a_report_no_select: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_item_ff.result_kind == RES_REPORT |->
         !out_item_ff.select_active && out_item_ff.tx_byte == CMD_NONE)
      else $error("report carries select or a byte");

   a_idle_positions: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_item_ff.pressed |->
         out_item_ff.x_position == '0 && out_item_ff.y_position == '0)
      else $error("positions set without a press");

   a_tx_select: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_item_ff.result_kind == RES_TX |->
         out_item_ff.select_active && !out_item_ff.pressed)
      else $error("transmit result without select");
`endif

endmodule
